FILE: hdl/gtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtp_pkg - shared definitions for the Goertzel tone power block
// Field widths, fixed-point shifts, register reset values and the register
// map of the configuration port.
// ----------------------------------------------------------------------------
package gtp_pkg;

    // Configuration register widths
    localparam int COEF_W = 15;
    localparam int LEN_W  = 8;

    // Result width and datapath widths
    localparam int POWER_W = 21;
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 2 * MUL_W;

    // Fixed-point scaling
    localparam int COEF_SHIFT  = 14;
    localparam int POWER_SHIFT = 11;

    // Register reset values
    localparam logic [COEF_W-1:0] COEF_RESET = 15'd30273;
    localparam logic [LEN_W-1:0]  LEN_RESET  = 8'd40;

    // Default parameter values
    localparam int SAMPLE_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Register map (index = paddr[2])
    typedef enum logic {
        REG_COEF = 1'b0,
        REG_LEN  = 1'b1
    } reg_index_t;

endpackage

FILE: hdl/gtp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtp_front - sample intake and block framing
// Accepts samples, counts them against the block length and tags the sample
// that closes a block before pushing it into the work queue.
// ----------------------------------------------------------------------------
module gtp_front #(
    parameter int SAMPLE_BITS = gtp_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [gtp_pkg::LEN_W-1:0] block_length,
    // sample transaction
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [SAMPLE_BITS-1:0]   in_sample,
    // queue push: {last, sample}
    output logic                     push_valid,
    input  logic                     push_ready,
    output logic [SAMPLE_BITS:0]     push_data
);
    import gtp_pkg::*;

    logic [LEN_W-1:0] count_reg, count_next;
    logic [LEN_W:0]   taken;
    logic [LEN_W:0]   len_eff;
    logic             last;
    logic             push;

    // a length of zero behaves as one
    assign len_eff = (block_length == '0) ? (LEN_W+1)'(1) : {1'b0, block_length};
    assign taken   = {1'b0, count_reg} + (LEN_W+1)'(1);
    assign last    = (taken >= len_eff);

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign push       = in_valid && push_ready;
    assign push_data  = {last, in_sample};

    // sample counter
    always_comb begin
        count_next = count_reg;
        if (push) begin
            count_next = last ? '0 : taken[LEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // closing sample restarts the count
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && last) |=> (count_reg == '0))
        else $error("sample count not cleared after block end");

endmodule

FILE: hdl/gtp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtp_fifo - short work queue
// Register-based first-in first-out queue with show-ahead read data, placed
// between intake and execution so each side can stall on its own.
// ----------------------------------------------------------------------------
module gtp_fifo #(
    parameter int DATA_W = gtp_pkg::SAMPLE_BITS_DEFAULT + 1,
    parameter int DEPTH  = gtp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  logic [DATA_W-1:0] wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output logic [DATA_W-1:0] rd_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              wr, rd;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;

    // pointer and fill level update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr && !rd) begin
            count_next = count_reg + CNT_W'(1);
        end else if (rd && !wr) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill level beyond depth");

endmodule

FILE: hdl/gtp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtp_back - recurrence and power sequencer
// Pops queued samples, runs the Goertzel recurrence and, on a closing sample,
// the power sum on one shared 32x32 multiplier; holds the result register.
// ----------------------------------------------------------------------------
module gtp_back #(
    parameter int SAMPLE_BITS = gtp_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [gtp_pkg::COEF_W-1:0]   coefficient,
    // queue pop: {last, sample}
    input  logic                         entry_valid,
    output logic                         entry_pop,
    input  logic [SAMPLE_BITS:0]         entry_data,
    // result transaction
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [gtp_pkg::POWER_W-1:0]  out_power
);
    import gtp_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_REC  = 7'b0000010,
        ST_P1   = 7'b0000100,
        ST_P2   = 7'b0001000,
        ST_P3   = 7'b0010000,
        ST_P4   = 7'b0100000,
        ST_OUT  = 7'b1000000
    } seq_state_t;

    seq_state_t                    state_reg, state_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] q1_reg, q1_next;
    logic signed [SAMPLE_BITS-1:0] q2_reg, q2_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          last_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [MUL_W-1:0]       acc_reg;
    logic [POWER_W-1:0]            power_reg;

    logic signed [MUL_W-1:0]       op_a, op_b;
    logic signed [PROD_W-1:0]      mul_full;
    logic signed [MUL_W-1:0]       q1_w, q2_w, coef_w, ac_w, pw;
    logic signed [MUL_W-1:0]       pw_sh;
    logic signed [SAMPLE_BITS-1:0] fb, q_new;
    logic                          out_free;
    logic                          load_out;

    assign q1_w   = MUL_W'(q1_reg);
    assign q2_w   = MUL_W'(q2_reg);
    assign coef_w = $signed(MUL_W'(coefficient));
    assign ac_w   = prod_reg[MUL_W-1:0];

    // shared multiplier operand select
    always_comb begin
        op_a = q1_w;
        op_b = coef_w;
        unique case (state_reg)
            ST_P1: begin
                op_a = q1_w;
                op_b = q1_w;
            end
            ST_P2: begin
                op_a = q2_w;
                op_b = q2_w;
            end
            ST_P4: begin
                op_a = ac_w >>> COEF_SHIFT;
                op_b = q2_w;
            end
            default: begin
                op_a = q1_w;
                op_b = coef_w;
            end
        endcase
    end

    assign mul_full = op_a * op_b;

    // recurrence: q = sample + (coef*q1 >>> 14) - q2, wrapping
    assign fb    = prod_reg[COEF_SHIFT+SAMPLE_BITS-1:COEF_SHIFT];
    assign q_new = sample_reg + fb - q2_reg;

    // power = (q1^2 + q2^2 - ((q1*coef) >>> 14) * q2) >>> 11
    assign pw    = acc_reg - prod_reg[MUL_W-1:0];
    assign pw_sh = pw >>> POWER_SHIFT;

    assign out_free  = !out_valid_reg || out_ready;
    assign load_out  = (state_reg == ST_OUT) && out_free;
    assign entry_pop = (state_reg == ST_IDLE) && entry_valid;

    // sequencer
    always_comb begin
        state_next     = state_reg;
        q1_next        = q1_reg;
        q2_next        = q2_reg;
        out_valid_next = out_valid_reg;
        if (out_ready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (entry_valid) begin
                    state_next = ST_REC;
                end
            end
            ST_REC: begin
                q2_next    = q1_reg;
                q1_next    = q_new;
                state_next = last_reg ? ST_P1 : ST_IDLE;
            end
            ST_P1: state_next = ST_P2;
            ST_P2: state_next = ST_P3;
            ST_P3: state_next = ST_P4;
            ST_P4: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    q1_next        = '0;
                    q2_next        = '0;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            q1_reg        <= '0;
            q2_reg        <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            q1_reg        <= q1_next;
            q2_reg        <= q2_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (entry_pop) begin
            sample_reg <= entry_data[SAMPLE_BITS-1:0];
            last_reg   <= entry_data[SAMPLE_BITS];
        end
        if (entry_pop || state_reg == ST_P1 || state_reg == ST_P2 ||
            state_reg == ST_P3 || state_reg == ST_P4) begin
            prod_reg <= mul_full;
        end
        if (state_reg == ST_P2) begin
            acc_reg <= prod_reg[MUL_W-1:0];
        end else if (state_reg == ST_P3) begin
            acc_reg <= acc_reg + prod_reg[MUL_W-1:0];
        end
        if (load_out) begin
            power_reg <= pw_sh[POWER_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_power = power_reg;

    a_clear_after_block: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> (q1_reg == '0 && q2_reg == '0 && out_valid_reg))
        else $error("state not cleared or result missing after block end");

    a_pop_starts_rec: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_pop |=> (state_reg == ST_REC))
        else $error("popped sample not processed");

endmodule

FILE: hdl/goertzel_tone_power.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// goertzel_tone_power - fixed-point Goertzel tone power detector
// One signed sample per input transaction; one power result per block of
// block_length samples. Coefficient and block length are set over APB.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream : one sample per transaction, s_tdata[SAMPLE_BITS-1:0].
//   m_* stream : one power result per finished block, m_tdata[20:0].
//   APB        : 0x0 coefficient (15 bits), 0x4 block_length (8 bits);
//                write only while no block work is pending.
// Throughput: samples are taken every cycle while the work queue has room.
//   The execution sequencer passes a sample that does not close a block
//   through its idle and recurrence states, and a closing sample also through
//   the power states and the output state, all on the single shared 32x32
//   multiplier; it pops a new sample only from the idle state.
// Result path: a closing sample leaving the queue goes through the recurrence,
//   power and output states; the result loads when the output register is free.
// Reset: the recurrence state and sample count clear, the registers return
//   to coefficient 30273 and block length 40.
// Stall: a result waits in the output register; the sequencer holds on the
//   next closing sample and the queue then fills and drops s_tready.
// ----------------------------------------------------------------------------
module goertzel_tone_power #(
    parameter int SAMPLE_BITS = gtp_pkg::SAMPLE_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = gtp_pkg::QUEUE_DEPTH_DEFAULT,
    localparam int S_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [SAMPLE_BITS-1:0] sample, rest zero
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // [20:0] power, [23:21] zero
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import gtp_pkg::*;

    logic [COEF_W-1:0]    coef_reg;
    logic [LEN_W-1:0]     len_reg;
    logic                 cfg_wr;
    reg_index_t           reg_sel;

    logic                 push_valid, push_ready;
    logic [SAMPLE_BITS:0] push_data;
    logic                 entry_valid, entry_pop;
    logic [SAMPLE_BITS:0] entry_data;
    logic [POWER_W-1:0]   power;

    // configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = reg_index_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= COEF_RESET;
            len_reg  <= LEN_RESET;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_COEF: coef_reg <= pwdata[COEF_W-1:0];
                REG_LEN:  len_reg  <= pwdata[LEN_W-1:0];
                default:  ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_sel)
            REG_COEF: prdata = 32'(coef_reg);
            REG_LEN:  prdata = 32'(len_reg);
            default:  prdata = '0;
        endcase
    end

    // intake and framing
    gtp_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .block_length(len_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_sample   (s_tdata[SAMPLE_BITS-1:0]),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    // work queue
    gtp_fifo #(
        .DATA_W(SAMPLE_BITS + 1),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_valid(push_valid),
        .wr_ready(push_ready),
        .wr_data (push_data),
        .rd_valid(entry_valid),
        .rd_ready(entry_pop),
        .rd_data (entry_data)
    );

    // execution
    gtp_back #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .coefficient(coef_reg),
        .entry_valid(entry_valid),
        .entry_pop  (entry_pop),
        .entry_data (entry_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_power  (power)
    );

    assign m_tdata = {3'b000, power};

endmodule
